[rtl/jfsd_pkg.sv]
// Shared types and constants of the jump-flood signed distance unit.
// No dependencies; imported by the top level.
`default_nettype none
package jfsd_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // magnitude limit of the Q10.4 distance
    localparam logic [13:0] SD_MAX = 14'h3FFF;

    // last neighbour read slot and the write slot of one pixel
    localparam logic [3:0] K_NB_LAST = 4'd8;
    localparam logic [3:0] K_WRITE   = 4'd9;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_RUN   = 2'd1,
        FN_READ  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COMP   = 2'd2,
        REG_EXTRA  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [14:0] sd;
        logic [7:0]         nx;
        logic [7:0]         ny;
        logic               found;
        logic               status;
    } res_t;

    // Neighbour offsets {ox, oy}, two-bit signed each: own pixel first,
    // then the eight others row by row.
    function automatic logic [3:0] nb_off(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd1:    r = 4'b1111;
            4'd2:    r = 4'b0011;
            4'd3:    r = 4'b0111;
            4'd4:    r = 4'b1100;
            4'd5:    r = 4'b0100;
            4'd6:    r = 4'b1101;
            4'd7:    r = 4'b0001;
            4'd8:    r = 4'b0101;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/jfsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module jfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/jump_flood_signed_distance_unit.sv]
// Top level of the jump-flood signed distance unit: mask store, two seed
// stores, pass sequencer and square-root unit. Uses jfsd_pkg and jfsd_ram.
`default_nettype none
// Usage:
//   Requests arrive on in_valid/in_stall with func, pixel_x, pixel_y and
//   occupied; every request gives one result on out_valid/out_stall.
//   Mask writes (also out of the image), unused codes and out-of-image reads
//   finish in the cycle they are taken; their result is registered.
//   A read first reads the mask and seed RAMs; if the pixel has a seed, the
//   digit-by-digit square root then retires one result bit per cycle.
//   A run seeds every pixel, one mask read per cycle, then each jump-flood
//   pass makes nine neighbour reads on the single seed read port plus one
//   write-back per pixel.
//   in_stall is high while a request is in work; the next request is taken
//   while a finished result still waits in the output register.
//   When out_stall holds a result, a second finished result parks in a hold
//   register until the output frees up.
//   Reset clears the control state, sets the size registers to 256x256 and
//   the comp and extra passes off; mask and seed contents stay undefined until
//   written. Configure only while idle.
module jump_flood_signed_distance_unit #(
    parameter int MAX_WIDTH  = jfsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = jfsd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [7:0]         pixel_x,
    input  wire logic [7:0]         pixel_y,
    input  wire logic               occupied,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [14:0]      signed_distance,
    output logic      [7:0]         nearest_x,
    output logic      [7:0]         nearest_y,
    output logic                    seed_found,
    output logic                    status
);
    import jfsd_pkg::*;

    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW    = $clog2(MAXD);
    localparam int LW0   = $clog2(MAXD + 1);
    localparam int LW    = (LW0 > 9) ? LW0 : 9;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SDW   = 2 * CW + 1;
    localparam int D2W   = 2 * CW + 1;
    localparam int RB    = CW + 5;
    localparam int VW    = 2 * RB;
    localparam int SW    = (CW > 3) ? CW : 3;
    localparam int NBW   = SW + 2;
    localparam int MW    = LW + 5;
    localparam int MGW   = (RB > MW) ? RB : MW;
    localparam int CNW   = $clog2(RB);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEED, ST_SEED_LAST, ST_PASS, ST_RD, ST_SQRT, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {PH_MAIN, PH_COMP, PH_EXTRA} phase_t;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
        return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
    endfunction

    function automatic logic [D2W-1:0] dist2(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] sx,
                                             input logic [CW-1:0] sy);
        logic signed [CW:0]     dx;
        logic signed [CW:0]     dy;
        logic signed [2*CW+1:0] qx;
        logic signed [2*CW+1:0] qy;
        dx = $signed({1'b0, x}) - $signed({1'b0, sx});
        dy = $signed({1'b0, y}) - $signed({1'b0, sy});
        qx = dx * dx;
        qy = dy * dy;
        return D2W'(qx) + D2W'(qy);
    endfunction

    // half the largest power of two not above m, at least one
    function automatic logic [SW-1:0] first_step(input logic [LW-1:0] m);
        logic [LW-1:0] p;
        p = LW'(1);
        for (int i = 0; i < LW; i++)
        begin
            if (m[i])
            begin
                p = LW'(1) << i;
            end
        end
        p = p >> 1;
        if (p == '0)
        begin
            p = LW'(1);
        end
        return SW'(p);
    endfunction

    function automatic logic signed [14:0] sd_of(input logic [MGW-1:0] mag,
                                                 input logic neg);
        logic [13:0]        s;
        logic signed [14:0] v;
        s = (mag > MGW'(SD_MAX)) ? SD_MAX : mag[13:0];
        v = $signed({1'b0, s});
        return neg ? -v : v;
    endfunction

    // configuration registers
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic       comp_reg;
    logic       extra_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            comp_reg   <= 1'b0;
            extra_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_COMP:   comp_reg   <= pwdata[0];
                REG_EXTRA:  extra_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {23'd0, height_reg};
            REG_COMP:   prdata = {31'd0, comp_reg};
            REG_EXTRA:  prdata = {31'd0, extra_reg};
        endcase
    end

    assign pready = 1'b1;

    logic [LW-1:0] w_eff;
    logic [LW-1:0] h_eff;
    logic [LW-1:0] m_eff;

    assign w_eff = (width_reg == '0) ? LW'(1) :
                   (LW'(width_reg) > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(width_reg);
    assign h_eff = (height_reg == '0) ? LW'(1) :
                   (LW'(height_reg) > LW'(MAX_HEIGHT)) ? LW'(MAX_HEIGHT) : LW'(height_reg);
    assign m_eff = (w_eff > h_eff) ? w_eff : h_eff;

    // control and datapath registers
    state_t           state_reg;
    phase_t           phase_reg;
    logic [SW-1:0]    step_reg;
    logic             cur_reg;
    logic [CW-1:0]    px_reg;
    logic [CW-1:0]    py_reg;
    logic [3:0]       k_reg;
    logic             cand_v_reg;
    logic [SDW-1:0]   best_reg;
    logic [D2W-1:0]   best_d2_reg;
    logic             pv_reg;
    logic [CW-1:0]    wx_reg;
    logic [CW-1:0]    wy_reg;
    logic             neg_reg;
    logic [CW-1:0]    nx_reg;
    logic [CW-1:0]    ny_reg;
    logic [VW-1:0]    rad_reg;
    logic [RB+2:0]    rem_reg;
    logic [RB-1:0]    root_reg;
    logic [CNW-1:0]   cnt_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;
    res_t             hold_res_reg;

    // request side
    logic          accept;
    logic          in_inside;
    logic [CW-1:0] in_x;
    logic [CW-1:0] in_y;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] scan_addr;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_inside = (LW'(pixel_x) < w_eff) && (LW'(pixel_y) < h_eff);
    assign in_x      = CW'(pixel_x);
    assign in_y      = CW'(pixel_y);
    assign in_addr   = addr_of(in_x, in_y);
    assign scan_addr = addr_of(px_reg, py_reg);

    // neighbour address of the current read slot
    logic [3:0]            off;
    logic signed [NBW-1:0] pxs;
    logic signed [NBW-1:0] pys;
    logic signed [NBW-1:0] stp;
    logic signed [NBW-1:0] nbx;
    logic signed [NBW-1:0] nby;
    logic                  nb_in;
    logic [AW-1:0]         nb_addr;

    assign off = nb_off(k_reg);
    assign pxs = $signed(NBW'(px_reg));
    assign pys = $signed(NBW'(py_reg));
    assign stp = $signed(NBW'(step_reg));
    assign nbx = (off[3:2] == 2'b11) ? pxs - stp : (off[3:2] == 2'b01) ? pxs + stp : pxs;
    assign nby = (off[1:0] == 2'b11) ? pys - stp : (off[1:0] == 2'b01) ? pys + stp : pys;
    assign nb_in = (nbx >= 0) && (nbx < $signed(NBW'(w_eff))) &&
                   (nby >= 0) && (nby < $signed(NBW'(h_eff)));
    assign nb_addr = addr_of(nbx[CW-1:0], nby[CW-1:0]);

    // memories
    logic           mask_we;
    logic           mask_rd;
    logic [AW-1:0]  mask_raddr;
    logic [AW-1:0]  seed_raddr;
    logic           seed_we;
    logic           seed_wtgt;
    logic [AW-1:0]  seed_waddr;
    logic [SDW-1:0] seed_wdata;
    logic [SDW-1:0] rd_a;
    logic [SDW-1:0] rd_b;
    logic [SDW-1:0] seed_rd;

    assign mask_we    = accept && (func_t'(func) == FN_WRITE) && in_inside;
    assign mask_raddr = (state_reg == ST_IDLE) ? in_addr : scan_addr;
    assign seed_raddr = (state_reg == ST_IDLE) ? in_addr : nb_addr;
    assign seed_rd    = cur_reg ? rd_b : rd_a;

    jfsd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mask (
        .clk   (clk),
        .we    (mask_we),
        .waddr (in_addr),
        .wdata (occupied),
        .raddr (mask_raddr),
        .rdata (mask_rd)
    );

    jfsd_ram #(.WIDTH(SDW), .DEPTH(DEPTH)) u_seed_a (
        .clk   (clk),
        .we    (seed_we && !seed_wtgt),
        .waddr (seed_waddr),
        .wdata (seed_wdata),
        .raddr (seed_raddr),
        .rdata (rd_a)
    );

    jfsd_ram #(.WIDTH(SDW), .DEPTH(DEPTH)) u_seed_b (
        .clk   (clk),
        .we    (seed_we && seed_wtgt),
        .waddr (seed_waddr),
        .wdata (seed_wdata),
        .raddr (seed_raddr),
        .rdata (rd_b)
    );

    // candidate compare; the same distance feeds the read path
    logic [D2W-1:0] cand_d2;
    logic [SDW-1:0] best_base;
    logic [D2W-1:0] d2_base;
    logic           take;
    logic [SDW-1:0] best_next;
    logic [D2W-1:0] d2_next;

    assign cand_d2   = dist2(px_reg, py_reg, seed_rd[2*CW-1:CW], seed_rd[CW-1:0]);
    assign best_base = (k_reg == 4'd1) ? '0 : best_reg;
    assign d2_base   = best_d2_reg;
    // only a strictly nearer seed replaces: the first found wins a tie
    assign take      = cand_v_reg && seed_rd[SDW-1] &&
                       (!best_base[SDW-1] || (cand_d2 < d2_base));
    assign best_next = take ? seed_rd : best_base;
    assign d2_next   = take ? cand_d2 : d2_base;

    always_comb
    begin
        seed_we    = 1'b0;
        seed_wtgt  = cur_reg;
        seed_waddr = addr_of(wx_reg, wy_reg);
        seed_wdata = mask_rd ? {1'b1, wx_reg, wy_reg} : '0;
        if ((state_reg == ST_SEED) || (state_reg == ST_SEED_LAST))
        begin
            seed_we = pv_reg;
        end
        else if (state_reg == ST_PASS)
        begin
            seed_we    = (k_reg == K_WRITE);
            seed_wtgt  = !cur_reg;
            seed_waddr = scan_addr;
            seed_wdata = best_next;
        end
    end

    // pass schedule
    logic          pix_last;
    logic          nxt_done;
    phase_t        nxt_phase;
    logic [SW-1:0] nxt_step;
    logic [SW-1:0] comp_step;
    logic [SW-1:0] extra_step;

    assign pix_last   = (LW'(px_reg) == w_eff - LW'(1)) && (LW'(py_reg) == h_eff - LW'(1));
    assign comp_step  = (m_eff >= LW'(2)) ? SW'(2) : SW'(1);
    assign extra_step = (m_eff >= LW'(4)) ? SW'(4) : comp_step;

    always_comb
    begin
        nxt_done  = 1'b0;
        nxt_phase = phase_reg;
        nxt_step  = step_reg;
        priority if ((phase_reg != PH_COMP) && (step_reg > SW'(1)))
        begin
            nxt_step = step_reg >> 1;
        end
        else if ((phase_reg == PH_COMP) && (step_reg == SW'(2)))
        begin
            nxt_step = SW'(1);
        end
        else if ((phase_reg == PH_MAIN) && comp_reg)
        begin
            nxt_phase = PH_COMP;
            nxt_step  = comp_step;
        end
        else if ((phase_reg != PH_EXTRA) && extra_reg)
        begin
            nxt_phase = PH_EXTRA;
            nxt_step  = extra_step;
        end
        else
        begin
            nxt_done = 1'b1;
        end
    end

    // square root, one result bit per cycle
    logic [RB+2:0] rem2;
    logic [RB+2:0] trial;
    logic          sq_ge;
    logic [RB+2:0] rem_nx;
    logic [RB-1:0] root_nx;

    assign rem2    = {rem_reg[RB:0], rad_reg[VW-1:VW-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sq_ge   = (rem2 >= trial);
    assign rem_nx  = sq_ge ? rem2 - trial : rem2;
    assign root_nx = {root_reg[RB-2:0], sq_ge};

    // finished result of this cycle
    logic fin_v;
    res_t fin_res;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        fin_v   = 1'b0;
        fin_res = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(func))
                        FN_WRITE:
                        begin
                            fin_v          = 1'b1;
                            fin_res.status = !in_inside;
                        end
                        FN_RUN:
                        begin
                            fin_v = 1'b0;
                        end
                        FN_READ:
                        begin
                            fin_v          = !in_inside;
                            fin_res.status = 1'b1;
                        end
                        default:
                        begin
                            fin_v = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                if (!seed_rd[SDW-1])
                begin
                    fin_v      = 1'b1;
                    fin_res.sd = sd_of(MGW'({m_eff, 5'b00000}), mask_rd);
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == CNW'(RB - 1))
                begin
                    fin_v         = 1'b1;
                    fin_res.sd    = sd_of(MGW'(root_nx), neg_reg);
                    fin_res.nx    = 8'(nx_reg);
                    fin_res.ny    = 8'(ny_reg);
                    fin_res.found = 1'b1;
                end
            end
            ST_PASS:
            begin
                fin_v = (k_reg == K_WRITE) && pix_last && nxt_done;
            end
            ST_SEED, ST_SEED_LAST, ST_EMIT:
            begin
                fin_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MAIN;
            step_reg      <= SW'(1);
            cur_reg       <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            k_reg         <= '0;
            cand_v_reg    <= 1'b0;
            best_reg      <= '0;
            best_d2_reg   <= '0;
            pv_reg        <= 1'b0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            neg_reg       <= 1'b0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            hold_res_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (func_t'(func) == FN_RUN))
                    begin
                        px_reg    <= '0;
                        py_reg    <= '0;
                        pv_reg    <= 1'b0;
                        state_reg <= ST_SEED;
                    end
                    else if (accept && (func_t'(func) == FN_READ) && in_inside)
                    begin
                        px_reg    <= in_x;
                        py_reg    <= in_y;
                        state_reg <= ST_RD;
                    end
                end
                ST_SEED:
                begin
                    // read mask at the scan point, write the seed in the following cycle
                    pv_reg <= 1'b1;
                    wx_reg <= px_reg;
                    wy_reg <= py_reg;
                    if (LW'(px_reg) == w_eff - LW'(1))
                    begin
                        px_reg <= '0;
                        if (LW'(py_reg) == h_eff - LW'(1))
                        begin
                            state_reg <= ST_SEED_LAST;
                        end
                        else
                        begin
                            py_reg <= py_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        px_reg <= px_reg + CW'(1);
                    end
                end
                ST_SEED_LAST:
                begin
                    pv_reg     <= 1'b0;
                    px_reg     <= '0;
                    py_reg     <= '0;
                    k_reg      <= '0;
                    cand_v_reg <= 1'b0;
                    phase_reg  <= PH_MAIN;
                    step_reg   <= first_step(m_eff);
                    state_reg  <= ST_PASS;
                end
                ST_PASS:
                begin
                    cand_v_reg  <= (k_reg <= K_NB_LAST) && nb_in;
                    best_reg    <= best_next;
                    best_d2_reg <= d2_next;
                    if (k_reg == K_WRITE)
                    begin
                        k_reg <= '0;
                        if (pix_last)
                        begin
                            // swap source and destination for the next pass
                            cur_reg   <= !cur_reg;
                            px_reg    <= '0;
                            py_reg    <= '0;
                            phase_reg <= nxt_phase;
                            step_reg  <= nxt_step;
                        end
                        else if (LW'(px_reg) == w_eff - LW'(1))
                        begin
                            px_reg <= '0;
                            py_reg <= py_reg + CW'(1);
                        end
                        else
                        begin
                            px_reg <= px_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_RD:
                begin
                    neg_reg  <= mask_rd;
                    nx_reg   <= seed_rd[2*CW-1:CW];
                    ny_reg   <= seed_rd[CW-1:0];
                    rad_reg  <= VW'({cand_d2, 8'h00});
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    if (seed_rd[SDW-1])
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    rad_reg  <= rad_reg << 2;
                    rem_reg  <= rem_nx;
                    root_reg <= root_nx;
                    cnt_reg  <= cnt_reg + CNW'(1);
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= hold_res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
            if (fin_v)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                    out_res_reg   <= fin_res;
                    state_reg     <= ST_IDLE;
                end
                else
                begin
                    hold_res_reg <= fin_res;
                    state_reg    <= ST_EMIT;
                end
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign signed_distance = out_res_reg.sd;
    assign nearest_x       = out_res_reg.nx;
    assign nearest_y       = out_res_reg.ny;
    assign seed_found      = out_res_reg.found;
    assign status          = out_res_reg.status;

endmodule
`default_nettype wire

[verif/tb_jump_flood_signed_distance_unit.sv]
// Self-checking testbench of the jump-flood signed distance unit: mask writes,
// flood runs and distance reads checked against a behavioral predictor.
// Depends on rtl/jfsd_pkg.sv and rtl/jump_flood_signed_distance_unit.sv.
`timescale 1ns / 1ps
module tb_jump_flood_signed_distance_unit;
    import jfsd_pkg::*;

    localparam logic [1:0] FN_NONE = 2'd3;

    typedef struct {
        logic [1:0] f;
        logic [7:0] x;
        logic [7:0] y;
        logic       occ;
    } request_t;

    typedef struct {
        logic signed [14:0] sd;
        logic [7:0]         nx;
        logic [7:0]         ny;
        logic               found;
        logic               status;
    } answer_t;

    typedef struct {
        logic [7:0] sx;
        logic [7:0] sy;
        logic       ok;
    } seed_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [7:0] pixel_x = '0;
    logic [7:0] pixel_y = '0;
    logic occupied = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [14:0] signed_distance;
    logic [7:0] nearest_x;
    logic [7:0] nearest_y;
    logic seed_found;
    logic status;

    jump_flood_signed_distance_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .occupied(occupied),
        .out_valid(out_valid), .out_stall(out_stall),
        .signed_distance(signed_distance), .nearest_x(nearest_x),
        .nearest_y(nearest_y), .seed_found(seed_found), .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    bit     mask_bits [65536];
    seed_t  seeds [65536];
    seed_t  seeds_next [65536];
    int     cfg_w = 256;
    int     cfg_h = 256;
    bit     cfg_comp = 0;
    bit     cfg_extra = 0;

    request_t pending_reqs [$];
    answer_t  expected_answers [$];
    int       n_accepted = 0;
    int       n_errors = 0;

    function automatic int used_w();
        return (cfg_w == 0) ? 1 : (cfg_w > 256 ? 256 : cfg_w);
    endfunction

    function automatic int used_h();
        return (cfg_h == 0) ? 1 : (cfg_h > 256 ? 256 : cfg_h);
    endfunction

    function automatic longint seed_dist2(int x, int y, seed_t s);
        longint dx;
        longint dy;
        dx = x - int'(s.sx);
        dy = y - int'(s.sy);
        return dx * dx + dy * dy;
    endfunction

    function automatic int int_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
                r = r + (longint'(1) << b);
        end
        return int'(r);
    endfunction

    function automatic void flood_pass(int step, int w, int h);
        seed_t  best;
        seed_t  c;
        longint bd;
        longint cd;
        int     sx;
        int     sy;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                best = seeds[y * 256 + x];
                bd = best.ok ? seed_dist2(x, y, best) : 64'h7FFF_FFFF_FFFF_FFFF;
                for (int oy = -1; oy <= 1; oy++)
                begin
                    for (int ox = -1; ox <= 1; ox++)
                    begin
                        sx = x + ox * step;
                        sy = y + oy * step;
                        if (sx >= 0 && sy >= 0 && sx < w && sy < h)
                        begin
                            c = seeds[sy * 256 + sx];
                            if (c.ok)
                            begin
                                cd = seed_dist2(x, y, c);
                                // strict compare: first candidate keeps a tie
                                if (cd < bd)
                                begin
                                    bd = cd;
                                    best = c;
                                end
                            end
                        end
                    end
                end
                seeds_next[y * 256 + x] = best;
            end
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                seeds[y * 256 + x] = seeds_next[y * 256 + x];
    endfunction

    function automatic void flood_fill();
        int w;
        int h;
        int m;
        int p;
        int step;
        w = used_w();
        h = used_h();
        m = (w > h) ? w : h;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                seeds[y * 256 + x].ok = mask_bits[y * 256 + x];
                seeds[y * 256 + x].sx = mask_bits[y * 256 + x] ? x[7:0] : 8'd0;
                seeds[y * 256 + x].sy = mask_bits[y * 256 + x] ? y[7:0] : 8'd0;
            end
        end
        p = 1;
        while ((p << 1) <= m)
            p = p << 1;
        step = (p / 2 < 1) ? 1 : p / 2;
        while (step >= 1)
        begin
            flood_pass(step, w, h);
            step = step / 2;
        end
        if (cfg_comp)
        begin
            if (m >= 2)
                flood_pass(2, w, h);
            flood_pass(1, w, h);
        end
        if (cfg_extra)
        begin
            if (m >= 4)
                flood_pass(4, w, h);
            if (m >= 2)
                flood_pass(2, w, h);
            flood_pass(1, w, h);
        end
    endfunction

    // advance the predictor by one accepted request and queue its answer
    function automatic void predict_answer(request_t r);
        answer_t a;
        int      w;
        int      h;
        int      mag;
        bit      in_image;
        seed_t   s;
        w = used_w();
        h = used_h();
        in_image = (int'(r.x) < w) && (int'(r.y) < h);
        a = '{sd: '0, nx: '0, ny: '0, found: 1'b0, status: 1'b0};
        if (r.f == FN_WRITE)
        begin
            if (in_image)
                mask_bits[int'(r.y) * 256 + int'(r.x)] = r.occ;
            else
                a.status = 1'b1;
        end
        else if (r.f == FN_RUN)
        begin
            flood_fill();
        end
        else if (r.f == FN_READ)
        begin
            if (!in_image)
            begin
                a.status = 1'b1;
            end
            else
            begin
                s = seeds[int'(r.y) * 256 + int'(r.x)];
                if (s.ok)
                begin
                    mag = int_sqrt(seed_dist2(r.x, r.y, s) * 256);
                    a.nx = s.sx;
                    a.ny = s.sy;
                    a.found = 1'b1;
                end
                else
                begin
                    mag = ((w > h) ? w : h) * 32;
                end
                if (mag > 16383)
                    mag = 16383;
                if (mask_bits[int'(r.y) * 256 + int'(r.x)])
                    mag = -mag;
                a.sd = mag[14:0];
            end
        end
        expected_answers = {expected_answers, a};
    endfunction

    function automatic int sender_idle_pct();
        if (n_accepted < 500)
            return 17;
        else if (n_accepted < 1000)
            return 77;
        return 0;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                predict_answer(pending_reqs.pop_front());
                n_accepted <= n_accepted + 1;
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct())
            begin
                r = pending_reqs[0];
                in_valid <= 1'b1;
                func <= r.f;
                pixel_x <= r.x;
                pixel_y <= r.y;
                occupied <= r.occ;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off once traffic is going
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(posedge clk or negedge rst_n)
    begin
        int pct;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            pct = (n_accepted < 500) ? 77 : ((n_accepted < 1000) ? 17 : 0);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && n_accepted >= 1100)
            begin
                hold_done <= 1;
                hold_left <= 400;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                e = expected_answers.pop_front();
                if (signed_distance !== e.sd)
                    report_mismatch("signed_distance", signed_distance, e.sd);
                if (nearest_x !== e.nx)
                    report_mismatch("nearest_x", nearest_x, e.nx);
                if (nearest_y !== e.ny)
                    report_mismatch("nearest_y", nearest_y, e.ny);
                if (seed_found !== e.found)
                    report_mismatch("seed_found", seed_found, e.found);
                if (status !== e.status)
                    report_mismatch("status", status, e.status);
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = value & 32'h1FF;
            REG_HEIGHT: cfg_h = value & 32'h1FF;
            REG_COMP:   cfg_comp = value[0];
            default:    cfg_extra = value[0];
        endcase
    endtask

    task automatic push_req(logic [1:0] f, int x, int y, bit occ);
        request_t r;
        r.f = f;
        r.x = x[7:0];
        r.y = y[7:0];
        r.occ = occ;
        pending_reqs = {pending_reqs, r};
    endtask

    // configure, write every mask pixel, run, then a mix of requests
    task automatic flood_phase(int wr, int hr, bit comp, bit extra, int occ_pct, int n_mix);
        int w;
        int h;
        int k;
        wait_drained();
        write_reg(REG_WIDTH, wr);
        write_reg(REG_HEIGHT, hr);
        write_reg(REG_COMP, comp);
        write_reg(REG_EXTRA, extra);
        w = used_w();
        h = used_h();
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                push_req(FN_WRITE, x, y, $urandom_range(99) < occ_pct);
        push_req(FN_RUN, $urandom_range(255), $urandom_range(255), $urandom_range(1));
        for (int i = 0; i < n_mix; i++)
        begin
            k = $urandom_range(99);
            if (k < 55)
                push_req(FN_READ, $urandom_range(w - 1), $urandom_range(h - 1), 0);
            else if (k < 72)
                push_req(FN_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
                         $urandom_range(1));
            else if (k < 86)
            begin
                // off-image coordinate, read or write (an in-image read at full size)
                if (w < 256)
                    push_req($urandom_range(1) ? FN_READ : FN_WRITE,
                             $urandom_range(255, w), $urandom_range(255), 1);
                else if (h < 256)
                    push_req($urandom_range(1) ? FN_READ : FN_WRITE,
                             $urandom_range(255), $urandom_range(255, h), 1);
                else
                    push_req(FN_READ, $urandom_range(w - 1), $urandom_range(h - 1), 0);
            end
            else if (k < 93)
                push_req(FN_NONE, $urandom_range(255), $urandom_range(255),
                         $urandom_range(1));
            else
                push_req(FN_RUN, 0, 0, 0);
        end
    endtask

    initial
    begin
        int dens;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: small image with all passes, empty mask for the fallback,
        // clamped sizes, a full-width single row and a fully occupied single pixel
        flood_phase(4, 3, 1, 1, 40, 24);
        flood_phase(5, 5, 0, 0, 0, 10);
        flood_phase(0, 511, 1, 0, 3, 20);
        flood_phase(256, 1, 0, 1, 3, 20);
        flood_phase(1, 1, 1, 1, 100, 6);
        while (n_accepted + pending_reqs.size() < 1450)
        begin
            case ($urandom_range(3))
                0: dens = 0;
                1: dens = 5;
                2: dens = 30;
                default: dens = 90;
            endcase
            flood_phase($urandom_range(1, 12), $urandom_range(1, 12),
                        $urandom_range(1), $urandom_range(1), dens, $urandom_range(30, 50));
        end
        wait_drained();
        repeat (100) @(posedge clk);
        if (n_errors == 0)
            $display("tb_jump_flood_signed_distance_unit: PASS");
        else
            $display("tb_jump_flood_signed_distance_unit: FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb_jump_flood_signed_distance_unit: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/jfsd_pkg.sv
rtl/jfsd_ram.sv
rtl/jump_flood_signed_distance_unit.sv
verif/tb_jump_flood_signed_distance_unit.sv
